FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the downsampler RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a result in the next cycle
`define ASSERT_NEXT(label, cond, res, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) else $error(msg);

`endif

FILE: hw/rtl/vdb2_pkg.sv
// ----------------------------------------------------------------------------
// vdb2_pkg
// Types and constants of the 2x2x2 box-average volume downsampler
// ----------------------------------------------------------------------------
`default_nettype none

package vdb2_pkg;

  // vector component width and accumulator width (room for eight terms)
  localparam int COMP_WIDTH = 16;
  localparam int SUM_WIDTH  = COMP_WIDTH + 3;
  localparam int COORD_W    = 5;

  // configuration port
  localparam int CFG_W      = 7;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_reg_t;

  // one voxel request
  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] comp_x;
    logic signed [COMP_WIDTH-1:0] comp_y;
    logic signed [COMP_WIDTH-1:0] comp_z;
  } in_item_t;

  // one reduced voxel
  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] mean_x;
    logic signed [COMP_WIDTH-1:0] mean_y;
    logic signed [COMP_WIDTH-1:0] mean_z;
    logic [COORD_W-1:0]           out_i;
    logic [COORD_W-1:0]           out_j;
    logic [COORD_W-1:0]           out_k;
    logic                         last_block;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vdb2_ram.sv
// ----------------------------------------------------------------------------
// vdb2_ram
// Simple dual-port RAM, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
`default_nettype none

module vdb2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                                      clk,
  input  wire                                      we,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                         wdata,
  input  wire                                      re,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/volume_downsample_box2_avg.sv
// ----------------------------------------------------------------------------
// volume_downsample_box2_avg
// 2x2x2 box-average downsampler for a raster stream of 3-component vectors
// ----------------------------------------------------------------------------
// Voxels enter on in_valid/in_ready in raster order (x outer, z inner) with
// the volume size held in three registers on the cfg_ port; the user must
// write them only while idle, which the block does not enforce. Each voxel
// inside the even-truncated volume is summed into a per-(y/2,z/2) accumulator
// held in one RAM; the first voxel of a block overwrites it. When the last
// voxel of a block arrives, the mean (sum >>> 3) and the reduced coordinates
// leave registered on out_valid/out_ready; last_block marks the final one.
// Throughput: one voxel per cycle while no held result stalls write-back;
// each voxel reads its accumulator when accepted and writes it back later;
// a write-back to the entry read in the same cycle is forwarded.
// When the receiver stalls, the output register holds its result; a further
// block result then waits in the write-back stage and in_ready drops until
// the output register frees. Voxels that produce no result keep flowing.
// Reset clears positions, pipeline valids and sizes (64, saturated to
// MAX_DIM); the accumulator RAM needs no clearing, each block writes first.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module volume_downsample_box2_avg #(
  parameter int MAX_DIM = 64
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  // voxel requests
  input  wire                                        in_valid,
  output logic                                       in_ready,
  input  wire  vdb2_pkg::in_item_t                   in_data,
  // reduced voxels
  output logic                                       out_valid,
  input  wire                                        out_ready,
  output vdb2_pkg::out_item_t                        out_data,
  // configuration writes
  input  wire                                        cfg_we,
  input  wire  [vdb2_pkg::CFG_ADDR_W-1:0]            cfg_addr,
  input  wire  [vdb2_pkg::CFG_W-1:0]                 cfg_wdata
);

  localparam int PW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int EW    = (PW + 1 > vdb2_pkg::CFG_W) ? PW + 1 : vdb2_pkg::CFG_W;
  localparam int HALF  = MAX_DIM / 2;
  localparam int DEPTH = HALF * HALF;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = vdb2_pkg::SUM_WIDTH;
  localparam int CW    = vdb2_pkg::COMP_WIDTH;
  localparam int MW    = 3 * SW;

  // size register as used: zero reads as one, large values saturate
  function automatic logic [EW-1:0] eff_size(input logic [vdb2_pkg::CFG_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (v == '0) begin
      return EW'(1);
    end else if (ve > EW'(MAX_DIM)) begin
      return EW'(MAX_DIM);
    end
    return ve;
  endfunction

  function automatic logic [SW-1:0] sext_comp(input logic [CW-1:0] c);
    return {{(SW - CW){c[CW-1]}}, c};
  endfunction

  logic [EW-1:0] size_x_r, size_y_r, size_z_r;
  logic [PW-1:0] pos_i_r, pos_j_r, pos_k_r;
  logic [PW-1:0] pos_i_nxt, pos_j_nxt, pos_k_nxt;

  // write-back stage
  logic                     s1_v_r, s1_first_r, s1_emit_r, s1_final_r;
  logic [AW-1:0]            s1_idx_r;
  vdb2_pkg::in_item_t       s1_comp_r;
  logic [vdb2_pkg::COORD_W-1:0] s1_i_r, s1_j_r, s1_k_r;
  logic                     fwd_r;
  logic [MW-1:0]            fwd_data_r;

  logic                     out_valid_r;
  vdb2_pkg::out_item_t      out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= eff_size(vdb2_pkg::SIZE_RESET);
      size_y_r <= eff_size(vdb2_pkg::SIZE_RESET);
      size_z_r <= eff_size(vdb2_pkg::SIZE_RESET);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        vdb2_pkg::CFG_SIZE_X: size_x_r <= eff_size(cfg_wdata);
        vdb2_pkg::CFG_SIZE_Y: size_y_r <= eff_size(cfg_wdata);
        vdb2_pkg::CFG_SIZE_Z: size_z_r <= eff_size(cfg_wdata);
        default: ;
      endcase
    end
  end

  // position decode of the incoming voxel
  logic [EW-1:0] pi_e, pj_e, pk_e, ex, ey, ez;
  logic          in_rng, v_first, v_emit, v_final;
  logic [AW-1:0] rd_idx;

  always_comb begin
    pi_e    = EW'(pos_i_r);
    pj_e    = EW'(pos_j_r);
    pk_e    = EW'(pos_k_r);
    ex      = {size_x_r[EW-1:1], 1'b0};
    ey      = {size_y_r[EW-1:1], 1'b0};
    ez      = {size_z_r[EW-1:1], 1'b0};
    in_rng  = (pi_e < ex) && (pj_e < ey) && (pk_e < ez);
    v_first = !(pos_i_r[0] || pos_j_r[0] || pos_k_r[0]);
    v_emit  = pos_i_r[0] && pos_j_r[0] && pos_k_r[0];
    v_final = (pi_e == ex - EW'(1)) && (pj_e == ey - EW'(1)) && (pk_e == ez - EW'(1));
    rd_idx  = AW'((pos_j_r >> 1) * HALF + (pos_k_r >> 1));
  end

  // raster advance, z fastest
  logic [EW-1:0] pi_inc, pj_inc, pk_inc;

  always_comb begin
    pi_inc    = pi_e + EW'(1);
    pj_inc    = pj_e + EW'(1);
    pk_inc    = pk_e + EW'(1);
    pos_i_nxt = pos_i_r;
    pos_j_nxt = pos_j_r;
    pos_k_nxt = PW'(pk_inc);
    if (pk_inc >= size_z_r) begin
      pos_k_nxt = '0;
      pos_j_nxt = PW'(pj_inc);
      if (pj_inc >= size_y_r) begin
        pos_j_nxt = '0;
        pos_i_nxt = PW'(pi_inc);
        if (pi_inc >= size_x_r) begin
          pos_i_nxt = '0;
        end
      end
    end
  end

  // handshake: write-back moves unless its result has nowhere to go
  logic s1_go, s1_wr, in_fire;

  assign s1_go    = !s1_emit_r || !out_valid_r || out_ready;
  assign s1_wr    = s1_v_r && s1_go;
  assign in_ready = !s1_v_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  // accumulate with forwarding from the previous write-back
  logic [MW-1:0] ram_rdata, base, wdata;
  logic [SW-1:0] sum_x, sum_y, sum_z;

  always_comb begin
    base  = fwd_r ? fwd_data_r : ram_rdata;
    if (s1_first_r) begin
      sum_x = sext_comp(s1_comp_r.comp_x);
      sum_y = sext_comp(s1_comp_r.comp_y);
      sum_z = sext_comp(s1_comp_r.comp_z);
    end else begin
      sum_x = base[3*SW-1:2*SW] + sext_comp(s1_comp_r.comp_x);
      sum_y = base[2*SW-1:SW]   + sext_comp(s1_comp_r.comp_y);
      sum_z = base[SW-1:0]      + sext_comp(s1_comp_r.comp_z);
    end
    wdata = {sum_x, sum_y, sum_z};
  end

  vdb2_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (s1_wr),
    .waddr (s1_idx_r),
    .wdata (wdata),
    .re    (in_fire),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // position and write-back stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_i_r <= '0;
      pos_j_r <= '0;
      pos_k_r <= '0;
      s1_v_r  <= 1'b0;
      fwd_r   <= 1'b0;
    end else if (in_fire) begin
      pos_i_r <= pos_i_nxt;
      pos_j_r <= pos_j_nxt;
      pos_k_r <= pos_k_nxt;
      s1_v_r  <= in_rng;
      fwd_r   <= s1_wr && (s1_idx_r == rd_idx);
    end else if (s1_wr) begin
      s1_v_r  <= 1'b0;
    end
  end

  // write-back stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_first_r <= v_first;
      s1_emit_r  <= v_emit;
      s1_final_r <= v_final;
      s1_idx_r   <= rd_idx;
      s1_comp_r  <= in_data;
      s1_i_r     <= vdb2_pkg::COORD_W'(pos_i_r >> 1);
      s1_j_r     <= vdb2_pkg::COORD_W'(pos_j_r >> 1);
      s1_k_r     <= vdb2_pkg::COORD_W'(pos_k_r >> 1);
      fwd_data_r <= wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_wr && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr && s1_emit_r) begin
      out_data_r.mean_x     <= sum_x[SW-1:3];
      out_data_r.mean_y     <= sum_y[SW-1:3];
      out_data_r.mean_z     <= sum_z[SW-1:3];
      out_data_r.out_i      <= s1_i_r;
      out_data_r.out_j      <= s1_j_r;
      out_data_r.out_k      <= s1_k_r;
      out_data_r.last_block <= s1_final_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `ASSERT_NEXT(a_fwd_set, in_fire && s1_wr && (s1_idx_r == rd_idx), fwd_r, "forward missed")
  `ASSERT_CLK(a_out_src, $rose(out_valid_r) |-> $past(s1_v_r && s1_emit_r), "stray result")
  `ASSERT_NEXT(a_s1_hold, s1_v_r && !s1_go, s1_v_r && $stable(s1_idx_r), "stall lost voxel")
  `ASSERT_CLK(a_no_accept_stall, (s1_v_r && !s1_go) |-> !in_ready, "accept over stall")

endmodule

`default_nettype wire
